/* rtl/mf_pkg.sv */
// ============================================================================
// mf_pkg
// Shared types, constants and compare helpers of the 3x3 RGB median filter.
// ============================================================================
package mf_pkg;

    // Field widths
    localparam int PIX_W     = 8;
    localparam int COL_OUT_W = 10;
    localparam int ROW_W     = 12;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    // Compare width for positions, sizes and the pending count
    localparam int CMP_W     = 14;

    // Register defaults and limits
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int HEIGHT_LIMIT  = 4096;

    // APB
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // One pixel, channel 0 red, 1 green, 2 blue
    typedef logic [2:0][PIX_W-1:0] t_rgb;

    // Effective frame size
    typedef struct packed {
        logic [CMP_W-1:0] width;
        logic [CMP_W-1:0] height;
    } t_cfg;

    // One window column: top, middle and the new pixel
    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_column;

    // Result attributes
    typedef struct packed {
        logic                 interior;
        logic                 last;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
    } t_meta;

    // One queue entry: a column that enters the window, maybe with a result
    typedef struct packed {
        t_column col;
        logic    emit;
        t_meta   meta;
    } t_job;

    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] md;
        logic [PIX_W-1:0] hi;
    } t_sort3;

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return min2(min2(a, b), c);
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_sort3 sort3(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] c);
        t_sort3 s;
        s.lo = min3(a, b, c);
        s.md = med3(a, b, c);
        s.hi = max3(a, b, c);
        return s;
    endfunction

endpackage

/* rtl/mf_stream_if.sv */
// ============================================================================
// mf_in_if / mf_out_if
// Valid/ready channels for input pixels and filtered results.
// ============================================================================
interface mf_in_if import mf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             flush;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, flush, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, flush, in_red, in_green, in_blue, output ready);
endinterface

interface mf_out_if import mf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     out_red;
    logic [PIX_W-1:0]     out_green;
    logic [PIX_W-1:0]     out_blue;
    logic [COL_OUT_W-1:0] out_col;
    logic [ROW_W-1:0]     out_row;
    logic                 frame_last;

    modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                    frame_last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_col, out_row,
                    frame_last, output ready);
endinterface

/* rtl/mf_regs.sv */
// ============================================================================
// mf_regs
// APB register file for frame width and height, with clamped sizes out.
// ============================================================================
module mf_regs import mf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    t_reg_idx            reg_idx;
    logic                wr_en;
    logic [CMP_W-1:0]    width_x;
    logic [CMP_W-1:0]    height_x;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(WIDTH_RESET);
            r_height <= HEIGHT_W'(HEIGHT_RESET);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    // Zero acts as one, oversize acts as the limit
    assign width_x  = CMP_W'(r_width);
    assign height_x = CMP_W'(r_height);

    always_comb begin
        if (width_x == '0)
            o_cfg.width = CMP_W'(1);
        else if (width_x > CMP_W'(MAX_WIDTH))
            o_cfg.width = CMP_W'(MAX_WIDTH);
        else
            o_cfg.width = width_x;

        if (height_x == '0)
            o_cfg.height = CMP_W'(1);
        else if (height_x > CMP_W'(HEIGHT_LIMIT))
            o_cfg.height = CMP_W'(HEIGHT_LIMIT);
        else
            o_cfg.height = height_x;
    end

endmodule

/* rtl/mf_queue.sv */
// ============================================================================
// mf_queue
// Short job queue between the front and the back of the filter.
// ============================================================================
module mf_queue import mf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_job              i_job,
    input  logic              i_pop,
    output t_job              o_job,
    output logic [QCNT_W-1:0] o_count
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= ptr_inc(r_wp);
            if (i_pop)  r_rp <= ptr_inc(r_rp);
            if (i_push && !i_pop)
                r_count <= r_count + QCNT_W'(1);
            else if (!i_push && i_pop)
                r_count <= r_count - QCNT_W'(1);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job   = r_mem[r_rp];
    assign o_count = r_count;

endmodule

/* rtl/mf_front.sv */
// ============================================================================
// mf_front
// Input side: position tracking, pending count, line stores and bypass.
// Each processed beat becomes one window column pushed into the job queue.
// ============================================================================
module mf_front import mf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    mf_in_if.sink             i_pix,
    input  logic [QCNT_W-1:0] i_q_count,
    output logic              o_push,
    output t_job              o_job
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Line stores
    t_rgb r_row_upper  [MAX_WIDTH];
    t_rgb r_row_middle [MAX_WIDTH];

    // Positions and pending count
    logic [CW-1:0]    r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [CW-1:0]    r_em_col;
    logic [ROW_W-1:0] r_em_row;
    logic [CMP_W-1:0] r_pending;

    // Store stage
    logic             r_b_valid;
    logic [CW-1:0]    r_b_addr;
    t_rgb             r_b_pix;
    logic             r_b_emit;
    t_meta            r_b_meta;
    t_rgb             r_rd_upper;
    t_rgb             r_rd_middle;
    logic             r_hit;
    t_rgb             r_fwd_upper;
    t_rgb             r_fwd_middle;

    logic             accept;
    logic             proc;
    logic             emit;
    logic             final_flush;
    logic [QCNT_W:0]  occ;
    t_rgb             pix;
    t_rgb             b_top;
    t_rgb             b_mid;
    logic [CMP_W-1:0] in_col_x;
    logic [CMP_W-1:0] in_row_x;
    logic [CMP_W-1:0] em_col_x;
    logic [CMP_W-1:0] em_row_x;
    logic [CMP_W-1:0] n_pending;
    logic [CW-1:0]    n_in_col;
    logic [ROW_W-1:0] n_in_row;
    logic [CW-1:0]    n_em_col;
    logic [ROW_W-1:0] n_em_row;
    t_meta            meta;

    // Room for everything in flight
    assign occ         = {1'b0, i_q_count} + {{QCNT_W{1'b0}}, r_b_valid};
    assign i_pix.ready = occ < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept      = i_pix.valid && i_pix.ready;

    // A flush with nothing pending is dropped
    assign proc        = accept && !(i_pix.flush && (r_pending == '0));
    assign emit        = i_pix.flush || (r_pending > i_cfg.width);
    assign final_flush = i_pix.flush && (r_pending == CMP_W'(1));
    assign pix         = i_pix.flush ? '0 : {i_pix.in_blue, i_pix.in_green, i_pix.in_red};

    always_comb begin
        if (i_pix.flush)
            n_pending = r_pending - CMP_W'(1);
        else if (emit)
            n_pending = r_pending;
        else
            n_pending = r_pending + CMP_W'(1);
    end

    // Next input and emit positions, raster wrap at the frame size
    assign in_col_x = CMP_W'(r_in_col);
    assign in_row_x = CMP_W'(r_in_row);
    assign em_col_x = CMP_W'(r_em_col);
    assign em_row_x = CMP_W'(r_em_row);

    always_comb begin
        if (in_col_x + CMP_W'(1) >= i_cfg.width) begin
            n_in_col = '0;
            n_in_row = (in_row_x + CMP_W'(1) >= i_cfg.height) ? '0 : r_in_row + ROW_W'(1);
        end else begin
            n_in_col = r_in_col + CW'(1);
            n_in_row = r_in_row;
        end
        if (em_col_x + CMP_W'(1) >= i_cfg.width) begin
            n_em_col = '0;
            n_em_row = (em_row_x + CMP_W'(1) >= i_cfg.height) ? '0 : r_em_row + ROW_W'(1);
        end else begin
            n_em_col = r_em_col + CW'(1);
            n_em_row = r_em_row;
        end
    end

    // Result attributes at the emit position
    always_comb begin
        meta.interior = (em_col_x >= CMP_W'(1)) && (em_col_x + CMP_W'(2) <= i_cfg.width) &&
                        (em_row_x >= CMP_W'(1)) && (em_row_x + CMP_W'(2) <= i_cfg.height);
        meta.last     = (em_col_x + CMP_W'(1) == i_cfg.width) &&
                        (em_row_x + CMP_W'(1) == i_cfg.height);
        meta.col      = COL_OUT_W'(r_em_col);
        meta.row      = r_em_row;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_em_col  <= '0;
            r_em_row  <= '0;
            r_pending <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= proc;
            if (proc) begin
                r_pending <= n_pending;
                if (emit) begin
                    r_em_col <= n_em_col;
                    r_em_row <= n_em_row;
                end
                // last flush: next frame starts where the results left off
                if (final_flush) begin
                    r_in_col <= n_em_col;
                    r_in_row <= n_em_row;
                end else begin
                    r_in_col <= n_in_col;
                    r_in_row <= n_in_row;
                end
            end
        end
    end

    // Store stage payload and same-column bypass
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_b_addr     <= r_in_col;
            r_b_pix      <= pix;
            r_b_emit     <= emit;
            r_b_meta     <= meta;
            r_hit        <= r_b_valid && (r_b_addr == r_in_col);
            r_fwd_upper  <= b_mid;
            r_fwd_middle <= r_b_pix;
        end
    end

    // Line store read for each processed beat
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_rd_upper  <= r_row_upper[r_in_col];
            r_rd_middle <= r_row_middle[r_in_col];
        end
    end

    assign b_top = r_hit ? r_fwd_upper  : r_rd_upper;
    assign b_mid = r_hit ? r_fwd_middle : r_rd_middle;

    // Line store write: middle moves up, new pixel into middle
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_row_upper[r_b_addr]  <= b_mid;
            r_row_middle[r_b_addr] <= r_b_pix;
        end
    end

    assign o_push       = r_b_valid;
    assign o_job.col    = '{top: b_top, mid: b_mid, bot: r_b_pix};
    assign o_job.emit   = r_b_emit;
    assign o_job.meta   = r_b_meta;

endmodule

/* rtl/mf_back.sv */
// ============================================================================
// mf_back
// Output side: 3x3 window of presorted columns, median pipeline, result reg.
// The whole back advances together when the result register is free.
// ============================================================================
module mf_back import mf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_job   i_job,
    input  logic   i_job_valid,
    output logic   o_pop,
    mf_out_if.source o_res
);

    // Window: column 0 oldest, one sorted triple per channel
    t_sort3 r_win [3][3];
    t_rgb   r_cmid1;
    t_rgb   r_cmid2;

    logic   r_s1_valid;
    t_meta  r_s1_meta;

    logic   r_s2_valid;
    t_meta  r_s2_meta;
    t_rgb   r_s2_lo;
    t_rgb   r_s2_md;
    t_rgb   r_s2_hi;
    t_rgb   r_s2_ctr;

    logic   r_out_valid;
    t_rgb   r_out_pix;
    t_meta  r_out_meta;

    logic   adv;
    t_sort3 new_col [3];
    t_rgb   med;

    assign adv   = !r_out_valid || o_res.ready;
    assign o_pop = adv && i_job_valid;

    // Sort the entering column per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            new_col[ch] = sort3(i_job.col.top[ch], i_job.col.mid[ch], i_job.col.bot[ch]);
        end
    end

    // Window shift on every job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_win[c][ch] <= '0;
                end
            end
            r_cmid1 <= '0;
            r_cmid2 <= '0;
        end else if (o_pop) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_win[0][ch] <= r_win[1][ch];
                r_win[1][ch] <= r_win[2][ch];
                r_win[2][ch] <= new_col[ch];
            end
            r_cmid1 <= r_cmid2;
            r_cmid2 <= i_job.col.mid;
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_pop && i_job.emit;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Max of lows, median of middles, min of highs
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_meta <= i_job.meta;
            r_s2_meta <= r_s1_meta;
            r_s2_ctr  <= r_cmid1;
            for (int ch = 0; ch < 3; ch++) begin
                r_s2_lo[ch] <= max3(r_win[0][ch].lo, r_win[1][ch].lo, r_win[2][ch].lo);
                r_s2_md[ch] <= med3(r_win[0][ch].md, r_win[1][ch].md, r_win[2][ch].md);
                r_s2_hi[ch] <= min3(r_win[0][ch].hi, r_win[1][ch].hi, r_win[2][ch].hi);
            end
        end
    end

    // Final median of the three
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            med[ch] = med3(r_s2_lo[ch], r_s2_md[ch], r_s2_hi[ch]);
        end
    end

    // Result register, border pixels pass unchanged
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pix  <= r_s2_meta.interior ? med : r_s2_ctr;
            r_out_meta <= r_s2_meta;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_red    = r_out_pix[0];
    assign o_res.out_green  = r_out_pix[1];
    assign o_res.out_blue   = r_out_pix[2];
    assign o_res.out_col    = r_out_meta.col;
    assign o_res.out_row    = r_out_meta.row;
    assign o_res.frame_last = r_out_meta.last;

endmodule

/* rtl/median_filter_3x3_rgb.sv */
// ============================================================================
// median_filter_3x3_rgb
// 3x3 per-channel median filter for an RGB pixel stream in raster order.
// ============================================================================
// Usage:
//   i_pix carries pixel beats (flush = 0) and flush beats (flush = 1). A
//   result for a pixel leaves on o_res once the pixel one row and one column
//   later has entered, i.e. W+1 pixel beats behind. After a frame's last
//   pixel, each flush beat releases one pending result; flush beats with
//   nothing pending are taken and dropped. Results carry column, row and a
//   frame_last mark; border pixels pass unchanged.
//   The APB port holds image_width (0x0) and image_height (0x4); write them
//   only while the block is idle.
//   Throughput: one beat per clock, both ways. The result of a beat that
//   releases one passes the store stage (line store read), the job queue,
//   the window and s1 stage, the s2 stage and the result register.
//   When o_res stalls the back holds and the 4-entry job queue fills; i_pix
//   ready drops once queue plus store stage hold four jobs.
//   Reset clears positions, the pending count, the window and all valids;
//   the line stores need no clearing and the block is ready at once.
// ============================================================================
module median_filter_3x3_rgb import mf_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mf_in_if.sink                 i_pix,
    mf_out_if.source              o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg              cfg;
    logic              q_push;
    logic              q_pop;
    t_job              q_in;
    t_job              q_out;
    logic [QCNT_W-1:0] q_count;

    mf_regs #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_pix     (i_pix),
        .i_q_count (q_count),
        .o_push    (q_push),
        .o_job     (q_in)
    );

    mf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_count (q_count)
    );

    mf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_out),
        .i_job_valid (q_count != '0),
        .o_pop       (q_pop),
        .o_res       (o_res)
    );

    // Credit check upstream must keep the queue from overflowing
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("job queue pushed while full");

    // Back side only takes jobs that are there
    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_count != '0))
        else $error("job queue popped while empty");

    // Queue level moves by at most one per cycle; checked here for a push without a pop
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> (q_count == $past(q_count) + QCNT_W'(1)))
        else $error("job queue level out of step");

endmodule
